// ----- rtl/fcd_pkg.sv -----
// Shared types, constants and the CDF knot table of the foot contact detector.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package fcd_pkg;

    // Field widths
    localparam int LEG_W       = 2;
    localparam int FORCE_W     = 16;
    localparam int PHASE_W     = 16;
    localparam int OFFSET_W    = 15;
    localparam int SCALE_W     = 16;
    localparam int PROB_W      = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Legs that the leg field can address
    localparam int LEG_PORT_LEGS     = 1 << LEG_W;
    localparam int LEG_COUNT_DEFAULT = 4;

    // Opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_SETUP  = 1'b1;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FORCE_OFFSET    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORCE_SCALE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_OFFSET     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_SCALE      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SWING_THRESHOLD = 3'd4;

    // Register reset values
    localparam logic [OFFSET_W-1:0] FORCE_OFFSET_RST    = 15'd640;
    localparam logic [SCALE_W-1:0]  FORCE_SCALE_RST     = 16'd1324;
    localparam logic [OFFSET_W-1:0] RATE_OFFSET_RST     = 15'd256;
    localparam logic [SCALE_W-1:0]  RATE_SCALE_RST      = 16'd16549;
    localparam logic [PHASE_W-1:0]  SWING_THRESHOLD_RST = 16'd39322;

    // The erf argument is in Q.20 and spans [-4, 4); the table has a power of two
    // number of cells, so a cell's left edge is the argument with its low bits cleared.
    localparam int CDF_TABLE_ENTRIES = 256;
    localparam int POS_W             = 23;
    localparam int KNOT_SHIFT        = 18;
    localparam int CELL_SHIFT        = POS_W - $clog2(CDF_TABLE_ENTRIES);
    localparam int ARG_HALF_RANGE    = 1 << (POS_W - 1);
    localparam logic [POS_W-1:0] CELL_MASK = ~(POS_W'((1 << CELL_SHIFT) - 1));

    // Decision threshold on the summed probabilities
    localparam logic [PROB_W:0] HALF_PROB = 17'd32768;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic                      is_setup;
        logic [LEG_W-1:0]          leg;
        logic signed [FORCE_W-1:0] force_req;
        logic                      late_swing;
        logic                      stance;
    } item_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] force_offset;
        logic [SCALE_W-1:0]  force_scale;
        logic [OFFSET_W-1:0] rate_offset;
        logic [SCALE_W-1:0]  rate_scale;
    } cfg_t;

    // P(x) = 0.5 + 0.5 erf(x) in Q0.16 at x = -4 + k/4
    function automatic logic [PROB_W-1:0] knot_cdf(input logic [5:0] k);
        logic [PROB_W-1:0] p;
        begin
            unique case (k)
                6'd0:    p = 16'd0;
                6'd1:    p = 16'd0;
                6'd2:    p = 16'd0;
                6'd3:    p = 16'd0;
                6'd4:    p = 16'd1;
                6'd5:    p = 16'd3;
                6'd6:    p = 16'd13;
                6'd7:    p = 16'd48;
                6'd8:    p = 16'd153;
                6'd9:    p = 16'd437;
                6'd10:   p = 16'd1111;
                6'd11:   p = 16'd2526;
                6'd12:   p = 16'd5154;
                6'd13:   p = 16'd9465;
                6'd14:   p = 16'd15712;
                6'd15:   p = 16'd23713;
                6'd16:   p = 16'd32768;
                6'd17:   p = 16'd41823;
                6'd18:   p = 16'd49824;
                6'd19:   p = 16'd56071;
                6'd20:   p = 16'd60382;
                6'd21:   p = 16'd63010;
                6'd22:   p = 16'd64425;
                6'd23:   p = 16'd65099;
                6'd24:   p = 16'd65383;
                6'd25:   p = 16'd65488;
                6'd26:   p = 16'd65523;
                6'd27:   p = 16'd65533;
                default: p = 16'd65535;
            endcase
            return p;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/foot_contact_detector.sv -----
// Top level of the foot contact detector: configuration registers, front end and back end.
// Depends on fcd_pkg, fcd_front, fcd_back and fcd_cdf.
//
// Usage: one input transaction carries a leg's force sample with its swing and
// stance phase, or a setup opcode that primes the leg's last force. A sample
// produces one output transaction with the leg and its contact bit; a setup,
// or a leg beyond the fitted count, produces none.
// Throughput is one transaction per cycle while the receiver does not stall. A
// sample's result passes through the input queue, the force history stage, the
// CDF units' multiply, cell lookup and interpolation stages, then the output
// register.
// Reset clears the queue, the pipeline, every leg's force history and contact
// state, and returns the configuration registers to their defaults.
// When the receiver stalls, the output register holds its transaction and the
// whole back pipeline stops; the four-entry queue absorbs further input and
// in_ready falls once it is full.
// Configuration writes through cfg_we take effect at the next clock edge and
// are meant to be made while no transaction is in flight.
`default_nettype none

module foot_contact_detector #(
    parameter int LEG_COUNT = fcd_pkg::LEG_COUNT_DEFAULT
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [fcd_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [fcd_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  opcode,
    input  wire logic [fcd_pkg::LEG_W-1:0]             leg,
    input  wire logic signed [fcd_pkg::FORCE_W-1:0]    force_req,
    input  wire logic [fcd_pkg::PHASE_W-1:0]           swing_progress,
    input  wire logic [fcd_pkg::PHASE_W-1:0]           stance_phase,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [fcd_pkg::LEG_W-1:0]                  out_leg,
    output logic                                       contact
);

    fcd_pkg::cfg_t                   cfg_reg;
    logic [fcd_pkg::PHASE_W-1:0]     swing_threshold_reg;
    logic                            q_valid;
    logic                            q_pop;
    fcd_pkg::item_t                  q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.force_offset <= fcd_pkg::FORCE_OFFSET_RST;
            cfg_reg.force_scale  <= fcd_pkg::FORCE_SCALE_RST;
            cfg_reg.rate_offset  <= fcd_pkg::RATE_OFFSET_RST;
            cfg_reg.rate_scale   <= fcd_pkg::RATE_SCALE_RST;
            swing_threshold_reg  <= fcd_pkg::SWING_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fcd_pkg::CFG_FORCE_OFFSET:
                    cfg_reg.force_offset <= cfg_data[fcd_pkg::OFFSET_W-1:0];
                fcd_pkg::CFG_FORCE_SCALE:
                    cfg_reg.force_scale <= cfg_data;
                fcd_pkg::CFG_RATE_OFFSET:
                    cfg_reg.rate_offset <= cfg_data[fcd_pkg::OFFSET_W-1:0];
                fcd_pkg::CFG_RATE_SCALE:
                    cfg_reg.rate_scale <= cfg_data;
                fcd_pkg::CFG_SWING_THRESHOLD:
                    swing_threshold_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    fcd_front #(
        .LEG_COUNT (LEG_COUNT)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .leg             (leg),
        .force_req       (force_req),
        .swing_progress  (swing_progress),
        .stance_phase    (stance_phase),
        .swing_threshold (swing_threshold_reg),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop)
    );

    fcd_back #(
        .LEG_COUNT (LEG_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_leg   (out_leg),
        .contact   (contact)
    );

`ifndef SYNTHESIS
    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("back end popped an empty queue");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> q_valid)
        else $error("input stalled while the queue holds nothing");

    a_out_leg_fitted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(out_leg) < LEG_COUNT))
        else $error("result for a leg that is not fitted");

    a_pop_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_valid && !(in_valid && in_ready)) |=> !q_valid)
        else $error("queue filled without an input transaction");
`endif

endmodule

`default_nettype wire

// ----- rtl/fcd_front.sv -----
// Front end: accepts input transactions, classifies them and queues them.
// Depends on fcd_pkg for the queue entry type, opcodes and widths.
`default_nettype none

module fcd_front #(
    parameter int LEG_COUNT = fcd_pkg::LEG_COUNT_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               opcode,
    input  wire logic [fcd_pkg::LEG_W-1:0]          leg,
    input  wire logic signed [fcd_pkg::FORCE_W-1:0] force_req,
    input  wire logic [fcd_pkg::PHASE_W-1:0]        swing_progress,
    input  wire logic [fcd_pkg::PHASE_W-1:0]        stance_phase,
    input  wire logic [fcd_pkg::PHASE_W-1:0]        swing_threshold,
    output logic                                    q_valid,
    output fcd_pkg::item_t                          q_item,
    input  wire logic                               q_pop
);

    localparam int PTR_W   = $clog2(fcd_pkg::QUEUE_DEPTH);
    localparam int COUNT_W = $clog2(fcd_pkg::QUEUE_DEPTH + 1);

    fcd_pkg::item_t     queue_reg [fcd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    fcd_pkg::item_t     item_next;
    logic               leg_ok;
    logic               push;

    // Items for legs that are not fitted are taken and dropped here.
    assign leg_ok = int'(leg) < LEG_COUNT;

    assign in_ready = count_reg != COUNT_W'(fcd_pkg::QUEUE_DEPTH);
    assign push     = in_valid && in_ready && leg_ok;
    assign q_valid  = count_reg != '0;
    assign q_item   = queue_reg[rd_ptr_reg];

    always_comb
    begin
        item_next.is_setup   = opcode == fcd_pkg::OP_SETUP;
        item_next.leg        = leg;
        item_next.force_req  = force_req;
        item_next.late_swing = swing_progress > swing_threshold;
        item_next.stance     = stance_phase != '0;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= item_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/fcd_cdf.sv -----
// Three-stage normal-CDF unit: scales a difference, finds its table cell and
// interpolates between knots. Depends on fcd_pkg for the knot table and constants.
`default_nettype none

module fcd_cdf #(
    parameter int DIFF_W = 17
) (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic signed [DIFF_W-1:0]           diff,
    input  wire logic [fcd_pkg::SCALE_W-1:0]        scale,
    output logic [fcd_pkg::PROB_W-1:0]              prob
);

    localparam int ARG_W   = DIFF_W + fcd_pkg::SCALE_W + 1;
    localparam int FRAC_W  = fcd_pkg::KNOT_SHIFT;
    localparam int IPROD_W = fcd_pkg::PROB_W + FRAC_W;
    localparam logic signed [ARG_W-1:0] ARG_HIGH = ARG_W'(fcd_pkg::ARG_HALF_RANGE);
    localparam logic signed [ARG_W-1:0] ARG_LOW  = -ARG_HIGH;

    logic signed [ARG_W-1:0]      diff_ext;
    logic signed [ARG_W-1:0]      scale_ext;
    logic signed [ARG_W-1:0]      arg_reg;
    logic signed [ARG_W-1:0]      arg_shifted;
    logic [fcd_pkg::POS_W-1:0]    pos;
    logic [5:0]                   knot_lo;
    logic [5:0]                   knot_hi;
    logic [fcd_pkg::PROB_W-1:0]   lo_next;
    logic [fcd_pkg::PROB_W-1:0]   hi_next;
    logic [fcd_pkg::PROB_W-1:0]   lo_reg;
    logic [fcd_pkg::PROB_W-1:0]   span_reg;
    logic [FRAC_W-1:0]            frac_reg;
    logic [IPROD_W-1:0]           interp;
    logic [fcd_pkg::PROB_W-1:0]   prob_reg;

    assign diff_ext  = ARG_W'(diff);
    assign scale_ext = ARG_W'($signed({1'b0, scale}));

    // Arguments outside [-4, 4) clamp to the first or last cell.
    assign arg_shifted = arg_reg + ARG_HIGH;

    always_comb
    begin
        if (arg_reg < ARG_LOW)
        begin
            pos = '0;
        end
        else if (arg_reg >= ARG_HIGH)
        begin
            pos = fcd_pkg::CELL_MASK;
        end
        else
        begin
            pos = arg_shifted[fcd_pkg::POS_W-1:0] & fcd_pkg::CELL_MASK;
        end
    end

    assign knot_lo = {1'b0, pos[fcd_pkg::POS_W-1:fcd_pkg::KNOT_SHIFT]};
    assign knot_hi = knot_lo + 6'd1;
    assign lo_next = fcd_pkg::knot_cdf(knot_lo);
    assign hi_next = fcd_pkg::knot_cdf(knot_hi);

    assign interp = IPROD_W'(span_reg) * IPROD_W'(frac_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            arg_reg  <= diff_ext * scale_ext;
            lo_reg   <= lo_next;
            span_reg <= hi_next - lo_next;
            frac_reg <= pos[FRAC_W-1:0];
            prob_reg <= lo_reg + interp[IPROD_W-1:FRAC_W];
        end
    end

    assign prob = prob_reg;

endmodule

`default_nettype wire

// ----- rtl/fcd_back.sv -----
// Back end: per-leg force history, the two CDF units, the contact decision
// and the output register. Depends on fcd_pkg and fcd_cdf.
`default_nettype none

module fcd_back #(
    parameter int LEG_COUNT = fcd_pkg::LEG_COUNT_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               q_valid,
    input  wire fcd_pkg::item_t                     q_item,
    output logic                                    q_pop,
    input  wire fcd_pkg::cfg_t                      cfg,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [fcd_pkg::LEG_W-1:0]               out_leg,
    output logic                                    contact
);

    localparam int DEPTH = (LEG_COUNT < fcd_pkg::LEG_PORT_LEGS) ? LEG_COUNT
                                                                : fcd_pkg::LEG_PORT_LEGS;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FDIFF_W  = fcd_pkg::FORCE_W + 1;
    localparam int RDIFF_W  = fcd_pkg::FORCE_W + 2;

    logic                              advance;
    logic [IDX_W-1:0]                  rd_idx;
    logic [IDX_W-1:0]                  dec_idx;
    logic signed [fcd_pkg::FORCE_W-1:0] prev_force_reg [DEPTH];
    logic signed [FDIFF_W-1:0]         force_diff;
    logic signed [RDIFF_W-1:0]         rate_diff;
    logic signed [FDIFF_W-1:0]         force_diff_reg;
    logic signed [RDIFF_W-1:0]         rate_diff_reg;
    logic [fcd_pkg::PROB_W-1:0]        p_force;
    logic [fcd_pkg::PROB_W-1:0]        p_rate;
    logic                              prob_met;
    logic [3:0]                        valid_reg;
    fcd_pkg::item_t                    ctl_reg [4];
    logic [DEPTH-1:0]                  touch_reg;
    logic [DEPTH-1:0]                  held_reg;
    logic                              touch_next;
    logic                              held_next;
    logic                              out_valid_reg;
    logic [fcd_pkg::LEG_W-1:0]         out_leg_reg;
    logic                              contact_reg;

    // The whole back pipeline moves whenever the output register can take a word.
    assign advance = !out_valid_reg || out_ready;
    assign q_pop   = advance && q_valid;

    assign rd_idx  = q_item.leg[IDX_W-1:0];
    assign dec_idx = ctl_reg[3].leg[IDX_W-1:0];

    assign force_diff = FDIFF_W'(q_item.force_req) - $signed(FDIFF_W'(cfg.force_offset));
    assign rate_diff  = RDIFF_W'(prev_force_reg[rd_idx]) - RDIFF_W'(q_item.force_req)
                        - $signed(RDIFF_W'(cfg.rate_offset));

    // The force history is updated as an item enters, so the next item of the
    // same leg in the following cycle already sees this force.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                prev_force_reg[i] <= '0;
            end
        end
        else if (q_pop)
        begin
            prev_force_reg[rd_idx] <= q_item.force_req;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            force_diff_reg <= force_diff;
            rate_diff_reg  <= rate_diff;
            ctl_reg[0]     <= q_item;
            for (int s = 1; s < 4; s++)
            begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
        end
    end

    fcd_cdf #(
        .DIFF_W (FDIFF_W)
    ) u_force_cdf (
        .clk   (clk),
        .en    (advance),
        .diff  (force_diff_reg),
        .scale (cfg.force_scale),
        .prob  (p_force)
    );

    fcd_cdf #(
        .DIFF_W (RDIFF_W)
    ) u_rate_cdf (
        .clk   (clk),
        .en    (advance),
        .diff  (rate_diff_reg),
        .scale (cfg.rate_scale),
        .prob  (p_rate)
    );

    assign prob_met = ({1'b0, p_force} + {1'b0, p_rate}) > fcd_pkg::HALF_PROB;

    always_comb
    begin
        touch_next = touch_reg[dec_idx];
        held_next  = held_reg[dec_idx];
        if (ctl_reg[3].is_setup)
        begin
            touch_next = 1'b0;
        end
        else if (ctl_reg[3].late_swing && prob_met)
        begin
            // Touchdown is latched only once until stance or setup clears the flag.
            if (!touch_reg[dec_idx])
            begin
                held_next  = 1'b1;
                touch_next = 1'b1;
            end
        end
        else if (ctl_reg[3].stance)
        begin
            held_next  = 1'b1;
            touch_next = 1'b0;
        end
        else
        begin
            held_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            touch_reg     <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg     <= {valid_reg[2:0], q_valid};
            out_valid_reg <= valid_reg[3] && !ctl_reg[3].is_setup;
            if (valid_reg[3])
            begin
                touch_reg[dec_idx] <= touch_next;
                held_reg[dec_idx]  <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_leg_reg <= ctl_reg[3].leg;
            contact_reg <= held_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_leg   = out_leg_reg;
    assign contact   = contact_reg;

endmodule

`default_nettype wire
